[rtl/qau_pkg.sv]
package qau_pkg;

  // Component and scalar formats
  localparam int CW   = 16;            // component width, signed Q2.14
  localparam int FB   = 14;            // fraction bits of a component
  localparam int SCW  = 32;            // scalar result width
  localparam int PW   = 2 * CW + 1;    // one product, after optional negation
  localparam int SUMW = 2 * CW + 3;    // exact sum of four products
  localparam int SQW  = 2 * CW + 1;    // sum of squares, always non-negative
  localparam int RW   = (SQW + 1) / 2; // integer square root width
  localparam int DW   = SQW;           // divisor width

  // Pipeline timing
  localparam int U1_DLY = RW + CW + 2;  // first product unit to divider output
  localparam int U2_DLY = U1_DLY - 3;   // second product unit to divider output
  localparam int LAT    = 3 + RW + CW + 3;

  typedef logic signed [CW-1:0]  comp_t;
  typedef logic signed [SCW-1:0] scal_t;
  typedef comp_t [3:0]           quat_t;

  localparam comp_t CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam comp_t CMIN = {1'b1, {(CW-1){1'b0}}};

  typedef enum logic [2:0] {
    OP_MUL   = 3'd0,
    OP_SCALE = 3'd1,
    OP_DOT   = 3'd2,
    OP_LENSQ = 3'd3,
    OP_NORM  = 3'd4,
    OP_INV   = 3'd5,
    OP_ROT   = 3'd6
  } opcode_t;

  typedef struct packed {
    logic [2:0] opcode;
    comp_t      qa_x;
    comp_t      qa_y;
    comp_t      qa_z;
    comp_t      qa_w;
    comp_t      qb_x;
    comp_t      qb_y;
    comp_t      qb_z;
    comp_t      qb_w;
    comp_t      scale_factor;
  } in_item_t;

  typedef struct packed {
    comp_t res_x;
    comp_t res_y;
    comp_t res_z;
    comp_t res_w;
    scal_t res_scalar;
    logic  zero_length;
    logic  saturated;
  } out_item_t;

  // Results of the first product unit, carried to the output stage
  typedef struct packed {
    quat_t      comp;
    logic [3:0] sat;
    scal_t      scal;
    logic       scal_sat;
    logic       zl;
  } u1_bundle_t;

  // Results of the second product unit (rotate)
  typedef struct packed {
    quat_t      comp;
    logic [3:0] sat;
  } u2_bundle_t;

  // Operands for the divider, carried across the square root
  typedef struct packed {
    logic [3:0][CW-1:0] mag;
    logic [3:0]         neg;
    logic               inv;
    logic [DW-1:0]      sq;
  } div_op_t;

  // Hamilton product term table: lane i, term j is A[HA_IDX[j]] * B[HB_IDX[i][j]],
  // negated where bit j of H_NEG[i] is set. Lanes are x, y, z, w.
  localparam logic [1:0] HA_IDX [4] = '{2'd3, 2'd0, 2'd1, 2'd2};
  localparam logic [1:0] HB_IDX [4][4] = '{
    '{2'd0, 2'd3, 2'd2, 2'd1},
    '{2'd1, 2'd2, 2'd3, 2'd0},
    '{2'd2, 2'd1, 2'd0, 2'd3},
    '{2'd3, 2'd0, 2'd1, 2'd2}
  };
  localparam logic [3:0] H_NEG [4] = '{4'b1000, 4'b0010, 4'b0100, 4'b1110};

endpackage

[rtl/qau_delay.sv]
module qau_delay
  import qau_pkg::*;
#(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] sh_r [DEPTH];

  // Shift the payload one stage per advance
  always_ff @(posedge clk) begin
    if (en) begin
      sh_r[0] <= d_i;
      for (int k = 1; k < DEPTH; k++) begin
        sh_r[k] <= sh_r[k-1];
      end
    end
  end

  assign q_o = sh_r[DEPTH-1];

endmodule

[rtl/qau_dot4.sv]
module qau_dot4
  import qau_pkg::*;
(
  input  logic                   clk,
  input  logic                   en,
  input  comp_t                  p_i   [4][4],
  input  comp_t                  q_i   [4][4],
  input  logic [3:0]             neg_i [4],
  output comp_t                  comp_o [4],
  output logic [3:0]             sat_o,
  output logic signed [SUMW-1:0] sum0_o
);

  localparam logic signed [SUMW:0] HALF = (SUMW+1)'(64'd1 << (FB - 1));
  localparam logic signed [SUMW:0] MAXE = (SUMW+1)'(CMAX);
  localparam logic signed [SUMW:0] MINE = (SUMW+1)'(CMIN);

  logic signed [PW-1:0]   prod_nxt [4][4];
  logic signed [PW-1:0]   prod_r   [4][4];
  logic signed [SUMW-1:0] sum_nxt  [4];
  logic signed [SUMW-1:0] sum_r    [4];
  comp_t                  comp_nxt [4];
  comp_t                  comp_r   [4];
  logic [3:0]             sat_nxt;
  logic [3:0]             sat_r;
  logic signed [SUMW-1:0] sum0_r;

  // Stage 1: sixteen signed products
  always_comb begin
    logic signed [2*CW-1:0] raw;
    logic signed [PW-1:0]   ext;
    raw = '0;
    ext = '0;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        raw = (2*CW)'(p_i[i][j]) * (2*CW)'(q_i[i][j]);
        ext = PW'(raw);
        prod_nxt[i][j] = neg_i[i][j] ? -ext : ext;
      end
    end
  end

  // Stage 2: exact sum per lane
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sum_nxt[i] = SUMW'(prod_r[i][0]) + SUMW'(prod_r[i][1])
                 + SUMW'(prod_r[i][2]) + SUMW'(prod_r[i][3]);
    end
  end

  // Stage 3: round half up to the component grid and clamp
  always_comb begin
    logic signed [SUMW:0] rnd;
    logic signed [SUMW:0] sh;
    rnd = '0;
    sh  = '0;
    for (int i = 0; i < 4; i++) begin
      rnd = (SUMW+1)'(sum_r[i]) + HALF;
      sh  = rnd >>> FB;
      if (sh > MAXE) begin
        comp_nxt[i] = CMAX;
        sat_nxt[i]  = 1'b1;
      end else if (sh < MINE) begin
        comp_nxt[i] = CMIN;
        sat_nxt[i]  = 1'b1;
      end else begin
        comp_nxt[i] = sh[CW-1:0];
        sat_nxt[i]  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      sum_r  <= sum_nxt;
      comp_r <= comp_nxt;
      sat_r  <= sat_nxt;
      sum0_r <= sum_r[0];
    end
  end

  assign comp_o = comp_r;
  assign sat_o  = sat_r;
  assign sum0_o = sum0_r;

endmodule

[rtl/qau_sqrt.sv]
module qau_sqrt
  import qau_pkg::*;
(
  input  logic           clk,
  input  logic           en,
  input  logic [SQW-1:0] rad_i,
  output logic [RW-1:0]  root_o
);

  localparam int SQE = 2 * RW;

  logic [SQE-1:0] rad_nxt  [RW];
  logic [RW:0]    rem_nxt  [RW];
  logic [RW-1:0]  root_nxt [RW];
  logic [SQE-1:0] rad_r    [RW];
  logic [RW:0]    rem_r    [RW];
  logic [RW-1:0]  root_r   [RW];

  // One root bit per stage, two radicand bits consumed per stage
  always_comb begin
    logic [SQE-1:0] rad_in;
    logic [RW:0]    rem_in;
    logic [RW-1:0]  root_in;
    logic [RW+2:0]  rem_sh;
    logic [RW+2:0]  trial;
    logic [RW+2:0]  diff;
    rad_in  = '0;
    rem_in  = '0;
    root_in = '0;
    rem_sh  = '0;
    trial   = '0;
    diff    = '0;
    for (int k = 0; k < RW; k++) begin
      if (k == 0) begin
        rad_in  = SQE'(rad_i);
        rem_in  = '0;
        root_in = '0;
      end else begin
        rad_in  = rad_r[k-1];
        rem_in  = rem_r[k-1];
        root_in = root_r[k-1];
      end
      rem_sh = {rem_in, rad_in[SQE-1 -: 2]};
      trial  = {1'b0, root_in, 2'b01};
      diff   = rem_sh - trial;
      if (rem_sh >= trial) begin
        rem_nxt[k]  = diff[RW:0];
        root_nxt[k] = {root_in[RW-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = rem_sh[RW:0];
        root_nxt[k] = {root_in[RW-2:0], 1'b0};
      end
      rad_nxt[k] = rad_in << 2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= rad_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign root_o = root_r[RW-1];

endmodule

[rtl/qau_div.sv]
module qau_div
  import qau_pkg::*;
(
  input  logic          clk,
  input  logic          en,
  input  logic [CW-1:0] mag_i [4],
  input  logic [3:0]    neg_i,
  input  logic          inv_i,
  input  logic [DW-1:0] d_i,
  output comp_t         comp_o [4],
  output logic [3:0]    sat_o
);

  localparam int NW   = CW + 2 * FB;
  localparam int R0W  = 2 * FB;
  localparam int CMPW = (R0W > DW) ? R0W : DW;
  localparam int NS   = CW + 1;
  localparam logic [CW:0] QMAXP = {2'b00, {(CW-1){1'b1}}};
  localparam logic [CW:0] QMAXN = {2'b01, {(CW-1){1'b0}}};

  logic [DW-1:0] rem_nxt [4][NS];
  logic [CW-1:0] quo_nxt [4][NS];
  logic [CW-1:0] nb_nxt  [4][NS];
  logic [DW-1:0] rem_r   [4][NS];
  logic [CW-1:0] quo_r   [4][NS];
  logic [CW-1:0] nb_r    [4][NS];
  logic [3:0]    ovf_nxt;
  logic [3:0]    ovf_r   [NS];
  logic [3:0]    neg_r   [NS];
  logic [DW-1:0] d_r     [NS];
  comp_t         comp_nxt [4];
  comp_t         comp_r   [4];
  logic [3:0]    sat_nxt;
  logic [3:0]    sat_r;

  // Setup: form the dividend, flag quotients too large for a component;
  // then restoring steps: one quotient bit per stage and lane
  always_comb begin
    logic [NW-1:0]  num;
    logic [R0W-1:0] r0;
    logic [DW:0]    rem_sh;
    logic [DW:0]    diff;
    num    = '0;
    r0     = '0;
    rem_sh = '0;
    diff   = '0;
    for (int i = 0; i < 4; i++) begin
      num = inv_i ? (NW'(mag_i[i]) << (2 * FB)) : (NW'(mag_i[i]) << FB);
      r0  = num[NW-1:CW];
      ovf_nxt[i]    = CMPW'(r0) >= CMPW'(d_i);
      rem_nxt[i][0] = ovf_nxt[i] ? '0 : DW'(r0);
      quo_nxt[i][0] = '0;
      nb_nxt[i][0]  = num[CW-1:0];
    end
    for (int i = 0; i < 4; i++) begin
      for (int k = 1; k < NS; k++) begin
        rem_sh = {rem_r[i][k-1], nb_r[i][k-1][CW-1]};
        diff   = rem_sh - {1'b0, d_r[k-1]};
        if (rem_sh >= {1'b0, d_r[k-1]}) begin
          rem_nxt[i][k] = diff[DW-1:0];
          quo_nxt[i][k] = {quo_r[i][k-1][CW-2:0], 1'b1};
        end else begin
          rem_nxt[i][k] = rem_sh[DW-1:0];
          quo_nxt[i][k] = {quo_r[i][k-1][CW-2:0], 1'b0};
        end
        nb_nxt[i][k] = nb_r[i][k-1] << 1;
      end
    end
  end

  // Final: round to nearest with ties away from zero, apply sign, clamp
  always_comb begin
    logic        rnd;
    logic [CW:0] qr;
    logic [CW:0] nq;
    rnd = 1'b0;
    qr  = '0;
    nq  = '0;
    for (int i = 0; i < 4; i++) begin
      rnd = {rem_r[i][NS-1], 1'b0} >= {1'b0, d_r[NS-1]};
      qr  = (CW+1)'(quo_r[i][NS-1]) + (CW+1)'(rnd);
      nq  = ~qr + 1'b1;
      if (!neg_r[NS-1][i]) begin
        if (ovf_r[NS-1][i] || qr > QMAXP) begin
          comp_nxt[i] = CMAX;
          sat_nxt[i]  = 1'b1;
        end else begin
          comp_nxt[i] = qr[CW-1:0];
          sat_nxt[i]  = 1'b0;
        end
      end else begin
        if (ovf_r[NS-1][i] || qr > QMAXN) begin
          comp_nxt[i] = CMIN;
          sat_nxt[i]  = 1'b1;
        end else begin
          comp_nxt[i] = nq[CW-1:0];
          sat_nxt[i]  = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r    <= rem_nxt;
      quo_r    <= quo_nxt;
      nb_r     <= nb_nxt;
      ovf_r[0] <= ovf_nxt;
      neg_r[0] <= neg_i;
      d_r[0]   <= d_i;
      for (int k = 1; k < NS; k++) begin
        ovf_r[k] <= ovf_r[k-1];
        neg_r[k] <= neg_r[k-1];
        d_r[k]   <= d_r[k-1];
      end
      comp_r <= comp_nxt;
      sat_r  <= sat_nxt;
    end
  end

  assign comp_o = comp_r;
  assign sat_o  = sat_r;

endmodule

[rtl/quaternion_arithmetic_unit_core.sv]
// Fixed-point quaternion ALU: Hamilton product, scale, dot product, length
// squared, normalize, inverse and vector rotation on signed Q2.14 components.
// Input channel in_valid/in_ready/in_data carries one operation per
// transaction; output channel out_valid/out_ready/out_data returns exactly one
// result per transaction, in order.
// Throughput: one transaction per cycle while out_ready is high or a bubble
// sits at the output register. Every opcode is timed by the normalize/inverse
// path (3 product stages, a 17-stage integer square root, an 18-stage
// restoring divider, the output register); shorter ones are delayed to match.
// Reset (rst_n low at a clock edge) drops every transaction in flight and
// clears out_valid; datapath registers are not cleared.
// When the receiver stalls, the whole pipeline holds; in_ready stays high as
// long as out_ready is high or a bubble sits at the output register, so
// transactions keep entering while earlier ones are still in the pipeline.
module quaternion_arithmetic_unit_core
  import qau_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam logic signed [SUMW-1:0] SMAX = SUMW'({1'b0, {(SCW-1){1'b1}}});
  localparam logic signed [SUMW-1:0] SMIN = -SMAX - SUMW'(1);

  logic                   adv;
  logic [LAT-1:0]         vld_r;
  logic [LAT-1:0]         vld_nxt;
  out_item_t              out_r;
  out_item_t              out_nxt;

  quat_t                  qa;
  quat_t                  qb;
  opcode_t                op0;
  comp_t                  p1 [4][4];
  comp_t                  q1 [4][4];
  logic [3:0]             neg1 [4];
  comp_t                  u1_comp [4];
  logic [3:0]             u1_sat;
  logic signed [SUMW-1:0] u1_sum0;

  quat_t                  qa3;
  logic [2:0]             op3_raw;
  opcode_t                op3;
  comp_t                  p2 [4][4];
  comp_t                  q2 [4][4];
  logic [3:0]             neg2 [4];
  comp_t                  u2_comp [4];
  logic [3:0]             u2_sat;

  u1_bundle_t             b1_in;
  u1_bundle_t             b1_out;
  u2_bundle_t             b2_in;
  u2_bundle_t             b2_out;
  div_op_t                dv_in;
  div_op_t                dv_out;
  logic [RW-1:0]          root;
  logic [CW-1:0]          dv_mag [4];
  logic [DW-1:0]          dv_d;
  comp_t                  dv_comp [4];
  logic [3:0]             dv_sat;
  logic [2:0]             op_end_raw;
  opcode_t                op_end;

  // Global advance: hold everything while a result waits at the output
  assign adv      = !vld_r[LAT-1] || out_ready;
  assign in_ready = adv;

  // Valid bits travel with the data
  assign vld_nxt = {vld_r[LAT-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  assign qa  = {in_data.qa_w, in_data.qa_z, in_data.qa_y, in_data.qa_x};
  assign qb  = {in_data.qb_w, in_data.qb_z, in_data.qb_y, in_data.qb_x};
  assign op0 = opcode_t'(in_data.opcode);

  // Operand routing for the first product unit
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      neg1[i] = '0;
      for (int j = 0; j < 4; j++) begin
        p1[i][j] = '0;
        q1[i][j] = '0;
      end
    end
    unique case (op0) inside
      OP_MUL, OP_ROT: begin
        for (int i = 0; i < 4; i++) begin
          neg1[i] = H_NEG[i];
          for (int j = 0; j < 4; j++) begin
            p1[i][j] = qa[HA_IDX[j]];
            if (op0 == OP_ROT && HB_IDX[i][j] == 2'd3) begin
              q1[i][j] = '0;
            end else begin
              q1[i][j] = qb[HB_IDX[i][j]];
            end
          end
        end
      end
      OP_SCALE: begin
        for (int i = 0; i < 4; i++) begin
          p1[i][0] = qa[i];
          q1[i][0] = in_data.scale_factor;
        end
      end
      OP_DOT: begin
        for (int j = 0; j < 4; j++) begin
          p1[0][j] = qa[j];
          q1[0][j] = qb[j];
        end
      end
      OP_LENSQ, OP_NORM, OP_INV: begin
        for (int j = 0; j < 4; j++) begin
          p1[0][j] = qa[j];
          q1[0][j] = qa[j];
        end
      end
      default: begin
      end
    endcase
  end

  qau_dot4 u_dot_a (
    .clk    (clk),
    .en     (adv),
    .p_i    (p1),
    .q_i    (q1),
    .neg_i  (neg1),
    .comp_o (u1_comp),
    .sat_o  (u1_sat),
    .sum0_o (u1_sum0)
  );

  // Carry A and the opcode alongside the first product unit
  qau_delay #(.WIDTH($bits(quat_t)), .DEPTH(3)) u_dly_qa (
    .clk (clk),
    .en  (adv),
    .d_i (qa),
    .q_o (qa3)
  );

  qau_delay #(.WIDTH(3), .DEPTH(3)) u_dly_op3 (
    .clk (clk),
    .en  (adv),
    .d_i (in_data.opcode),
    .q_o (op3_raw)
  );

  assign op3 = opcode_t'(op3_raw);

  // Second pass of rotate: (A*v) * conj(A), conjugate folded into the signs
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      neg2[i] = H_NEG[i];
      for (int j = 0; j < 4; j++) begin
        p2[i][j] = u1_comp[HA_IDX[j]];
        q2[i][j] = qa3[HB_IDX[i][j]];
        if (HB_IDX[i][j] != 2'd3) begin
          neg2[i][j] = !H_NEG[i][j];
        end
      end
    end
  end

  qau_dot4 u_dot_b (
    .clk    (clk),
    .en     (adv),
    .p_i    (p2),
    .q_i    (q2),
    .neg_i  (neg2),
    .comp_o (u2_comp),
    .sat_o  (u2_sat),
    .sum0_o ()
  );

  // Scalar clamp, zero-length test and divider operands
  always_comb begin
    logic nz;
    logic isneg;
    nz    = 1'b0;
    isneg = 1'b0;
    for (int i = 0; i < 4; i++) begin
      b1_in.comp[i] = u1_comp[i];
    end
    b1_in.sat = u1_sat;
    if (u1_sum0 > SMAX) begin
      b1_in.scal     = {1'b0, {(SCW-1){1'b1}}};
      b1_in.scal_sat = 1'b1;
    end else if (u1_sum0 < SMIN) begin
      b1_in.scal     = {1'b1, {(SCW-1){1'b0}}};
      b1_in.scal_sat = 1'b1;
    end else begin
      b1_in.scal     = u1_sum0[SCW-1:0];
      b1_in.scal_sat = 1'b0;
    end
    dv_in.sq  = u1_sum0[SQW-1:0];
    b1_in.zl  = (u1_sum0[SQW-1:0] == '0);
    dv_in.inv = (op3 == OP_INV);
    for (int i = 0; i < 4; i++) begin
      nz    = (qa3[i] != '0);
      isneg = qa3[i][CW-1];
      dv_in.mag[i] = isneg ? (~qa3[i] + 1'b1) : qa3[i];
      if (dv_in.inv && i < 3) begin
        dv_in.neg[i] = !isneg && nz;
      end else begin
        dv_in.neg[i] = isneg;
      end
    end
  end

  qau_delay #(.WIDTH($bits(u1_bundle_t)), .DEPTH(U1_DLY)) u_dly_b1 (
    .clk (clk),
    .en  (adv),
    .d_i (b1_in),
    .q_o (b1_out)
  );

  qau_delay #(.WIDTH(3), .DEPTH(U1_DLY)) u_dly_op_end (
    .clk (clk),
    .en  (adv),
    .d_i (op3_raw),
    .q_o (op_end_raw)
  );

  assign op_end = opcode_t'(op_end_raw);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      b2_in.comp[i] = u2_comp[i];
    end
    b2_in.sat = u2_sat;
  end

  qau_delay #(.WIDTH($bits(u2_bundle_t)), .DEPTH(U2_DLY)) u_dly_b2 (
    .clk (clk),
    .en  (adv),
    .d_i (b2_in),
    .q_o (b2_out)
  );

  // Length for normalize
  qau_sqrt u_sqrt (
    .clk    (clk),
    .en     (adv),
    .rad_i  (dv_in.sq),
    .root_o (root)
  );

  qau_delay #(.WIDTH($bits(div_op_t)), .DEPTH(RW)) u_dly_dv (
    .clk (clk),
    .en  (adv),
    .d_i (dv_in),
    .q_o (dv_out)
  );

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      dv_mag[i] = dv_out.mag[i];
    end
    dv_d = dv_out.inv ? dv_out.sq : DW'(root);
  end

  qau_div u_div (
    .clk    (clk),
    .en     (adv),
    .mag_i  (dv_mag),
    .neg_i  (dv_out.neg),
    .inv_i  (dv_out.inv),
    .d_i    (dv_d),
    .comp_o (dv_comp),
    .sat_o  (dv_sat)
  );

  // Select the result for the opcode
  always_comb begin
    out_nxt = '0;
    unique case (op_end) inside
      OP_MUL, OP_SCALE: begin
        out_nxt.res_x     = b1_out.comp[0];
        out_nxt.res_y     = b1_out.comp[1];
        out_nxt.res_z     = b1_out.comp[2];
        out_nxt.res_w     = b1_out.comp[3];
        out_nxt.saturated = |b1_out.sat;
      end
      OP_DOT, OP_LENSQ: begin
        out_nxt.res_scalar = b1_out.scal;
        out_nxt.saturated  = b1_out.scal_sat;
      end
      OP_NORM, OP_INV: begin
        if (b1_out.zl) begin
          out_nxt.zero_length = 1'b1;
        end else begin
          out_nxt.res_x     = dv_comp[0];
          out_nxt.res_y     = dv_comp[1];
          out_nxt.res_z     = dv_comp[2];
          out_nxt.res_w     = dv_comp[3];
          out_nxt.saturated = |dv_sat;
        end
      end
      OP_ROT: begin
        out_nxt.res_x     = b2_out.comp[0];
        out_nxt.res_y     = b2_out.comp[1];
        out_nxt.res_z     = b2_out.comp[2];
        out_nxt.saturated = (|b1_out.sat) | (|b2_out.sat);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = vld_r[LAT-1];
  assign out_data  = out_r;

endmodule
